FILE: sv/axis_angle_rotation_matrix_macros.svh
// assertion macros for the axis-angle rotation matrix block
// expects clk and arst_n in the scope of the module that uses them
`ifndef AXIS_ANGLE_ROTATION_MATRIX_MACROS_SVH
`define AXIS_ANGLE_ROTATION_MATRIX_MACROS_SVH

// same-cycle implication
`define AARM_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define AARM_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/aarm_pkg.sv
// types, widths and constants of the axis-angle rotation matrix block
// no dependencies
`default_nettype none

package aarm_pkg;

	localparam int TH_W     = 40;
	localparam int XY_W     = 34;
	localparam int R_W      = 32;
	localparam int Q_W      = 61;
	localparam int RES_W    = 62;
	localparam int SQ_W     = 31;
	localparam int SQ_STEPS = 31;
	localparam int NCELL    = Q_W + SQ_STEPS;

	localparam logic signed [TH_W-1:0] PI_Q30      = 40'sd3373259426;
	localparam logic signed [TH_W-1:0] TWO_PI_Q30  = 40'sd6746518852;
	localparam logic signed [TH_W-1:0] HALF_PI_Q30 = 40'sd1686629713;
	localparam logic signed [XY_W-1:0] GAIN_Q30    = 34'sd652032874;

	typedef struct packed {
		logic signed [15:0] angle;
		logic signed [15:0] axis_x;
		logic signed [15:0] axis_y;
		logic signed [15:0] axis_z;
	} item_t;

	typedef struct packed {
		logic signed [15:0] m_c0_r0;
		logic signed [15:0] m_c0_r1;
		logic signed [15:0] m_c0_r2;
		logic signed [15:0] m_c1_r0;
		logic signed [15:0] m_c1_r1;
		logic signed [15:0] m_c1_r2;
		logic signed [15:0] m_c2_r0;
		logic signed [15:0] m_c2_r1;
		logic signed [15:0] m_c2_r2;
		logic               zero_axis;
	} result_t;

	typedef struct packed {
		logic [2:0]                  sgn;
		logic [R_W-1:0]              b;
		logic [2:0][R_W-1:0]         r;
		logic [2:0][Q_W-1:0]         q;
		logic [2:0][RES_W-1:0]       res;
		logic signed [TH_W-1:0]      th;
		logic signed [XY_W-1:0]      x;
		logic signed [XY_W-1:0]      y;
		logic                        neg;
		logic                        ang_zero;
		logic                        axis_zero;
	} tok_t;

	function automatic logic signed [TH_W-1:0] atan_q30(input int i);
		logic signed [TH_W-1:0] t;
		unique case (i)
			0: t = 40'sd843314857;
			1: t = 40'sd497837829;
			2: t = 40'sd263043837;
			3: t = 40'sd133525159;
			4: t = 40'sd67021687;
			5: t = 40'sd33543516;
			6: t = 40'sd16775851;
			7: t = 40'sd8388437;
			8: t = 40'sd4194283;
			9: t = 40'sd2097149;
			default: t = (i <= 30) ? (40'sd1 <<< (30 - i)) : '0;
		endcase
		return t;
	endfunction

endpackage

`default_nettype wire

FILE: sv/aarm_front.sv
// input stages: squares of the axis, norm squared, angle in q30
// depends on aarm_pkg
`default_nettype none

module aarm_front import aarm_pkg::*; #(
	parameter int ANGLE_FRAC_BITS = 13
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  vld_in,
	input  item_t item,
	output logic  vld,
	output tok_t  tok
);

	logic [2:0][15:0]      ax;
	logic [2:0][15:0]      mag;
	logic [2:0][31:0]      prod;
	logic signed [TH_W-1:0] th0;

	logic                  vld_s1;
	logic [2:0][SQ_W-1:0]  sq_s1;
	logic [2:0]            sgn_s1;
	logic signed [TH_W-1:0] th_s1;
	logic                  ang_zero_s1;

	logic                  vld_s2;
	tok_t                  tok_s2;
	logic [R_W-1:0]        n2;

	assign ax = {item.axis_z, item.axis_y, item.axis_x};

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			mag[l]  = ax[l][15] ? 16'(-ax[l]) : ax[l];
			prod[l] = 32'(mag[l]) * 32'(mag[l]);
		end
		th0 = {{(TH_W-16){item.angle[15]}}, item.angle} <<< (30 - ANGLE_FRAC_BITS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
		end
	end

	assign n2 = R_W'(sq_s1[0]) + R_W'(sq_s1[1]) + R_W'(sq_s1[2]);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				sq_s1[l]  <= prod[l][SQ_W-1:0];
				sgn_s1[l] <= ax[l][15];
			end
			th_s1       <= th0;
			ang_zero_s1 <= (item.angle == 16'sd0);

			tok_s2.sgn       <= sgn_s1;
			tok_s2.b         <= n2;
			for (int l = 0; l < 3; l++) begin
				tok_s2.r[l] <= R_W'(sq_s1[l]);
			end
			tok_s2.q         <= '0;
			tok_s2.res       <= '0;
			tok_s2.th        <= th_s1;
			tok_s2.x         <= GAIN_Q30;
			tok_s2.y         <= '0;
			tok_s2.neg       <= 1'b0;
			tok_s2.ang_zero  <= ang_zero_s1;
			tok_s2.axis_zero <= (n2 == '0);
		end
	end

	assign vld = vld_s2;
	assign tok = tok_s2;

endmodule

`default_nettype wire

FILE: sv/aarm_cell.sv
// one cell of the chain: a divide or root bit per axis lane and at most one angle step
// depends on aarm_pkg
`default_nettype none

module aarm_cell import aarm_pkg::*; #(
	parameter int IDX             = 0,
	parameter int ANGLE_FRAC_BITS = 13,
	parameter int CORDIC_STAGES   = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic vld_in,
	input  tok_t tok_in,
	output logic vld,
	output tok_t tok
);

	localparam int NRED     = (ANGLE_FRAC_BITS < 13) ? (14 - ANGLE_FRAC_BITS) : 1;
	localparam int RED_J    = (IDX < NRED) ? (NRED - 1 - IDX) : 0;
	localparam int CFIRST   = NRED + 1;
	localparam int CI       = (IDX >= CFIRST) ? (IDX - CFIRST) : 0;
	localparam int SQ_J     = (IDX >= Q_W) ? (IDX - Q_W) : 0;
	localparam logic [RES_W-1:0] BIT = 62'd1 << (60 - 2 * SQ_J);
	localparam logic signed [TH_W-1:0] RED_D = TWO_PI_Q30 <<< RED_J;

	tok_t                  nxt;
	logic [2:0][R_W:0]     r2;
	logic [2:0][RES_W-1:0] rb;
	logic [2:0][RES_W-1:0] vx;
	logic signed [XY_W-1:0] xs;
	logic signed [XY_W-1:0] ys;
	logic signed [TH_W-1:0] at;

	logic                  vld_s1;
	tok_t                  tok_s1;

	always_comb begin
		nxt = tok_in;
		xs  = tok_in.x >>> CI;
		ys  = tok_in.y >>> CI;
		at  = atan_q30(CI);
		for (int l = 0; l < 3; l++) begin
			r2[l] = {tok_in.r[l], 1'b0};
			rb[l] = tok_in.res[l] + BIT;
			vx[l] = {1'b0, tok_in.q[l]};
			if (IDX == 0) begin
				if (tok_in.r[l] >= tok_in.b) begin
					nxt.r[l] = tok_in.r[l] - tok_in.b;
					nxt.q[l] = Q_W'(1);
				end
			end else if (IDX < Q_W) begin
				if (r2[l] >= {1'b0, tok_in.b}) begin
					nxt.r[l] = R_W'(r2[l] - {1'b0, tok_in.b});
					nxt.q[l] = {tok_in.q[l][Q_W-2:0], 1'b1};
				end else begin
					nxt.r[l] = r2[l][R_W-1:0];
					nxt.q[l] = {tok_in.q[l][Q_W-2:0], 1'b0};
				end
			end else begin
				if (vx[l] >= rb[l]) begin
					nxt.q[l]   = Q_W'(vx[l] - rb[l]);
					nxt.res[l] = (tok_in.res[l] >> 1) + BIT;
				end else begin
					nxt.res[l] = tok_in.res[l] >> 1;
				end
			end
		end
		if (IDX < NRED) begin
			if (tok_in.th - RED_D > -PI_Q30) begin
				nxt.th = tok_in.th - RED_D;
			end else if (tok_in.th + RED_D <= PI_Q30) begin
				nxt.th = tok_in.th + RED_D;
			end
		end else if (IDX == NRED) begin
			if (tok_in.th > HALF_PI_Q30) begin
				nxt.th  = tok_in.th - PI_Q30;
				nxt.neg = 1'b1;
			end else if (tok_in.th < -HALF_PI_Q30) begin
				nxt.th  = tok_in.th + PI_Q30;
				nxt.neg = 1'b1;
			end
		end else if (IDX < CFIRST + CORDIC_STAGES) begin
			if (tok_in.th >= 0) begin
				nxt.x  = tok_in.x - ys;
				nxt.y  = tok_in.y + xs;
				nxt.th = tok_in.th - at;
			end else begin
				nxt.x  = tok_in.x + ys;
				nxt.y  = tok_in.y - xs;
				nxt.th = tok_in.th + at;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tok_s1 <= nxt;
		end
	end

	assign vld = vld_s1;
	assign tok = tok_s1;

endmodule

`default_nettype wire

FILE: sv/aarm_tail.sv
// output stages: unit axis and sin/cos products, sums, rounding, identity select
// depends on aarm_pkg
`default_nettype none

module aarm_tail import aarm_pkg::*; #(
	parameter int COEF_FRAC_BITS = 14
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  logic    vld_in,
	input  tok_t    tok_in,
	output logic    vld,
	output result_t res
);

	localparam int SH = 30 - COEF_FRAC_BITS;
	localparam logic signed [36:0] HALF = (37'sd1 <<< SH) >>> 1;
	localparam logic signed [36:0] ONE  = 37'sd1 <<< COEF_FRAC_BITS;
	localparam logic [31:0] ONE_W = 32'd1 << COEF_FRAC_BITS;
	localparam logic [15:0] ONE16 = ONE_W[15:0];

	function automatic logic [15:0] to_out(input logic signed [35:0] v);
		logic signed [36:0] w;
		w = (37'(v) + HALF) >>> SH;
		if (w > ONE) begin
			w = ONE;
		end else if (w < -ONE) begin
			w = -ONE;
		end
		return w[15:0];
	endfunction

	logic [3:0]              vld_q;

	logic signed [31:0]      u_s1 [3];
	logic signed [XY_W-1:0]  c_s1, s_s1, omc_s1;
	logic                    ident_s1, zax_s1;

	logic signed [63:0]      pu [6];
	logic signed [65:0]      ps [3];
	logic signed [31:0]      p_s2 [6];
	logic signed [33:0]      su_s2 [3];
	logic signed [XY_W-1:0]  c_s2, omc_s2;
	logic                    ident_s2, zax_s2;

	logic signed [65:0]      pt [6];
	logic signed [33:0]      t_s3 [6];
	logic signed [33:0]      su_s3 [3];
	logic signed [XY_W-1:0]  c_s3;
	logic                    ident_s3, zax_s3;

	logic signed [35:0]      e [9];
	result_t                 r4;
	result_t                 res_s4;

	always_comb begin
		pu[0] = 64'(u_s1[0]) * 64'(u_s1[0]);
		pu[1] = 64'(u_s1[1]) * 64'(u_s1[1]);
		pu[2] = 64'(u_s1[2]) * 64'(u_s1[2]);
		pu[3] = 64'(u_s1[0]) * 64'(u_s1[1]);
		pu[4] = 64'(u_s1[0]) * 64'(u_s1[2]);
		pu[5] = 64'(u_s1[1]) * 64'(u_s1[2]);
		for (int k = 0; k < 3; k++) begin
			ps[k] = 66'(s_s1) * 66'(u_s1[k]);
		end
		for (int k = 0; k < 6; k++) begin
			pt[k] = 66'(omc_s2) * 66'(p_s2[k]);
		end
	end

	// element order: xx yy zz xy xz yz in t_s3, x y z in su_s3
	always_comb begin
		e[0] = 36'(c_s3) + 36'(t_s3[0]);
		e[1] = 36'(t_s3[3]) + 36'(su_s3[2]);
		e[2] = 36'(t_s3[4]) - 36'(su_s3[1]);
		e[3] = 36'(t_s3[3]) - 36'(su_s3[2]);
		e[4] = 36'(c_s3) + 36'(t_s3[1]);
		e[5] = 36'(t_s3[5]) + 36'(su_s3[0]);
		e[6] = 36'(t_s3[4]) + 36'(su_s3[1]);
		e[7] = 36'(t_s3[5]) - 36'(su_s3[0]);
		e[8] = 36'(c_s3) + 36'(t_s3[2]);
		if (ident_s3) begin
			r4         = '0;
			r4.m_c0_r0 = ONE16;
			r4.m_c1_r1 = ONE16;
			r4.m_c2_r2 = ONE16;
		end else begin
			r4.m_c0_r0 = to_out(e[0]);
			r4.m_c0_r1 = to_out(e[1]);
			r4.m_c0_r2 = to_out(e[2]);
			r4.m_c1_r0 = to_out(e[3]);
			r4.m_c1_r1 = to_out(e[4]);
			r4.m_c1_r2 = to_out(e[5]);
			r4.m_c2_r0 = to_out(e[6]);
			r4.m_c2_r1 = to_out(e[7]);
			r4.m_c2_r2 = to_out(e[8]);
		end
		r4.zero_axis = zax_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[2:0], vld_in};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				u_s1[l] <= tok_in.sgn[l] ? -32'(tok_in.res[l][30:0])
				                         : 32'(tok_in.res[l][30:0]);
			end
			c_s1     <= tok_in.neg ? -tok_in.x : tok_in.x;
			s_s1     <= tok_in.neg ? -tok_in.y : tok_in.y;
			omc_s1   <= (34'sd1 <<< 30) - (tok_in.neg ? -tok_in.x : tok_in.x);
			ident_s1 <= tok_in.ang_zero || tok_in.axis_zero;
			zax_s1   <= tok_in.axis_zero && !tok_in.ang_zero;

			for (int k = 0; k < 6; k++) begin
				p_s2[k] <= pu[k][61:30];
			end
			for (int k = 0; k < 3; k++) begin
				su_s2[k] <= ps[k][63:30];
			end
			c_s2     <= c_s1;
			omc_s2   <= omc_s1;
			ident_s2 <= ident_s1;
			zax_s2   <= zax_s1;

			for (int k = 0; k < 6; k++) begin
				t_s3[k] <= pt[k][63:30];
			end
			su_s3    <= su_s2;
			c_s3     <= c_s2;
			ident_s3 <= ident_s2;
			zax_s3   <= zax_s2;

			res_s4   <= r4;
		end
	end

	assign vld = vld_q[3];
	assign res = res_s4;

endmodule

`default_nettype wire

FILE: sv/axis_angle_rotation_matrix.sv
// axis-angle to 3x3 rotation matrix, top level: front stages, cell chain, tail, output register
// depends on aarm_pkg, aarm_front, aarm_cell, aarm_tail and the macros header
//
//  channel   dir  handshake                  beat
//  item      in   item_valid / item_ready    item_t: angle, axis_x, axis_y, axis_z
//  result    out  result_valid / result_ready result_t: nine elements, zero_axis
//
// one beat per cycle in, one per cycle out while the chain is not held; stages in order:
// 2 front stages, 92 cells (61 divide bits then 31 root bits, angle steps ride in the first
// cells), 4 tail stages and the output register
// reset clears only the valid bits; no clearing pass
// the chain holds only while the last tail stage and the output register are both full
// and result_ready is low
`default_nettype none
`include "axis_angle_rotation_matrix_macros.svh"

module axis_angle_rotation_matrix import aarm_pkg::*; #(
	parameter int ANGLE_FRAC_BITS = 13,
	parameter int COEF_FRAC_BITS  = 14,
	parameter int CORDIC_STAGES   = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	localparam logic [31:0] ONE_W = 32'd1 << COEF_FRAC_BITS;
	localparam logic [15:0] ONE16 = ONE_W[15:0];

	logic          en;
	logic [NCELL:0] cv;
	tok_t          ct [NCELL+1];
	logic          tail_vld;
	result_t       tail_res;
	logic          out_vld_q;
	result_t       result_q;

	assign en         = !(tail_vld && out_vld_q && !result_ready);
	assign item_ready = en;

	aarm_front #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (en),
		.vld_in(item_valid),
		.item  (item),
		.vld   (cv[0]),
		.tok   (ct[0])
	);

	for (genvar g = 0; g < NCELL; g++) begin : g_cell
		aarm_cell #(
			.IDX            (g),
			.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
			.CORDIC_STAGES  (CORDIC_STAGES)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.vld_in(cv[g]),
			.tok_in(ct[g]),
			.vld   (cv[g+1]),
			.tok   (ct[g+1])
		);
	end

	aarm_tail #(
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_tail (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (en),
		.vld_in(cv[NCELL]),
		.tok_in(ct[NCELL]),
		.vld   (tail_vld),
		.res   (tail_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (tail_vld && en) begin
			out_vld_q <= 1'b1;
		end else if (result_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tail_vld && en) begin
			result_q <= tail_res;
		end
	end

	assign result_valid = out_vld_q;
	assign result       = result_q;

	`AARM_ASSERT_IMP(a_zero_axis_identity, result_valid && result.zero_axis, result.m_c0_r0 == ONE16 && result.m_c1_r1 == ONE16 && result.m_c2_r2 == ONE16 && result.m_c0_r1 == 16'sd0, "zero axis result is not identity")
	`AARM_ASSERT_NXT(a_tail_holds, tail_vld && out_vld_q && !result_ready, tail_vld, "held tail beat was lost")
	`AARM_ASSERT_IMP(a_out_from_tail, $rose(result_valid), $past(tail_vld), "result appeared without a tail beat")

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// testbench for the axis-angle rotation matrix block: random and directed beats,
// a bit-exact rotation matrix predictor and an in-order scoreboard
// depends on aarm_pkg and axis_angle_rotation_matrix
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import aarm_pkg::*;

	localparam int ANG_FB   = 13;
	localparam int COEF_FB  = 14;
	localparam int STAGES   = 16;
	localparam int WFRAC    = 30;
	localparam int LATENCY  = 99;
	localparam int N_RANDOM = 1850;

	localparam longint PI_V      = 64'sd3373259426;
	localparam longint TWO_PI_V  = 64'sd6746518852;
	localparam longint HALF_PI_V = 64'sd1686629713;
	localparam longint GAIN_V    = 64'sd652032874;

	class matrix_scoreboard;
		result_t pending[$];
		int      errors;

		function new();
			errors = 0;
		endfunction

		static function longint floor_shift(longint v, int s);
			return v >>> s;
		endfunction

		static function longint arctan_step(int i);
			longint lo[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
				33543516, 16775851, 8388437, 4194283, 2097149};
			if (i < 10)
				return lo[i];
			if (i <= 30)
				return longint'(1) << (30 - i);
			return 0;
		endfunction

		static function longint unsigned root_u64(longint unsigned v);
			longint unsigned acc, bitv;
			acc = 0;
			bitv = 64'd1 << 62;
			while (bitv > v)
				bitv = bitv >> 2;
			while (bitv != 0) begin
				if (v >= acc + bitv) begin
					v = v - (acc + bitv);
					acc = (acc >> 1) + bitv;
				end else begin
					acc = acc >> 1;
				end
				bitv = bitv >> 2;
			end
			return acc;
		endfunction

		static function longint unit_axis(longint a, longint unsigned n2);
			longint unsigned mag, num, q, r;
			longint u;
			mag = (a < 0) ? -a : a;
			num = mag * mag;
			q = 0;
			r = num;
			if (r >= n2) begin
				q = 1;
				r = r - n2;
			end
			for (int k = 0; k < 60; k++) begin
				r = r << 1;
				q = q << 1;
				if (r >= n2) begin
					r = r - n2;
					q = q | 1;
				end
			end
			u = longint'(root_u64(q));
			return (a < 0) ? -u : u;
		endfunction

		static function logic signed [15:0] to_coef(longint v);
			longint one;
			int sh;
			one = longint'(1) << COEF_FB;
			sh = WFRAC - COEF_FB;
			v = (v + (longint'(1) << (sh - 1))) >>> sh;
			if (v > one)
				v = one;
			if (v < -one)
				v = -one;
			return v[15:0];
		endfunction

		static function longint mul_q(longint a, longint b);
			return (a * b) >>> WFRAC;
		endfunction

		static function result_t rotation_of(item_t it);
			result_t r;
			longint ang, a[3], u[3], th, x, y, t, c, s, omc;
			longint xx, yy, zz, xy, xz, yz, sx, sy, sz;
			longint unsigned n2;
			bit flip;
			ang = it.angle;
			a[0] = it.axis_x;
			a[1] = it.axis_y;
			a[2] = it.axis_z;
			n2 = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
			r = '0;
			if (ang == 0 || n2 == 0) begin
				r.m_c0_r0 = 16'sd1 <<< COEF_FB;
				r.m_c1_r1 = 16'sd1 <<< COEF_FB;
				r.m_c2_r2 = 16'sd1 <<< COEF_FB;
				r.zero_axis = (ang != 0);
				return r;
			end
			for (int i = 0; i < 3; i++)
				u[i] = unit_axis(a[i], n2);
			th = ang * (longint'(1) << (WFRAC - ANG_FB));
			x = GAIN_V;
			y = 0;
			flip = 0;
			while (th > PI_V)
				th -= TWO_PI_V;
			while (th <= -PI_V)
				th += TWO_PI_V;
			if (th > HALF_PI_V) begin
				th -= PI_V;
				flip = 1;
			end else if (th < -HALF_PI_V) begin
				th += PI_V;
				flip = 1;
			end
			for (int i = 0; i < STAGES; i++) begin
				if (th >= 0) begin
					t = x - floor_shift(y, i);
					y = y + floor_shift(x, i);
					th -= arctan_step(i);
				end else begin
					t = x + floor_shift(y, i);
					y = y - floor_shift(x, i);
					th += arctan_step(i);
				end
				x = t;
			end
			c = flip ? -x : x;
			s = flip ? -y : y;
			omc = (longint'(1) << WFRAC) - c;
			xx = mul_q(omc, mul_q(u[0], u[0]));
			yy = mul_q(omc, mul_q(u[1], u[1]));
			zz = mul_q(omc, mul_q(u[2], u[2]));
			xy = mul_q(omc, mul_q(u[0], u[1]));
			xz = mul_q(omc, mul_q(u[0], u[2]));
			yz = mul_q(omc, mul_q(u[1], u[2]));
			sx = mul_q(s, u[0]);
			sy = mul_q(s, u[1]);
			sz = mul_q(s, u[2]);
			r.m_c0_r0 = to_coef(c + xx);
			r.m_c0_r1 = to_coef(xy + sz);
			r.m_c0_r2 = to_coef(xz - sy);
			r.m_c1_r0 = to_coef(xy - sz);
			r.m_c1_r1 = to_coef(c + yy);
			r.m_c1_r2 = to_coef(yz + sx);
			r.m_c2_r0 = to_coef(xz + sy);
			r.m_c2_r1 = to_coef(yz - sx);
			r.m_c2_r2 = to_coef(c + zz);
			return r;
		endfunction

		function void note_item(item_t it);
			pending.push_back(rotation_of(it));
		endfunction

		function void check_field(string name, longint e, longint a);
			if (e != a) begin
				errors++;
				$display("%0t: %s mismatch expected %0d actual %0d", $realtime, name, e, a);
			end
		endfunction

		function void check_result(result_t got);
			result_t e;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: unexpected result expected none actual %h", $realtime, got);
				return;
			end
			e = pending.pop_front();
			check_field("m_c0_r0", e.m_c0_r0, got.m_c0_r0);
			check_field("m_c0_r1", e.m_c0_r1, got.m_c0_r1);
			check_field("m_c0_r2", e.m_c0_r2, got.m_c0_r2);
			check_field("m_c1_r0", e.m_c1_r0, got.m_c1_r0);
			check_field("m_c1_r1", e.m_c1_r1, got.m_c1_r1);
			check_field("m_c1_r2", e.m_c1_r2, got.m_c1_r2);
			check_field("m_c2_r0", e.m_c2_r0, got.m_c2_r0);
			check_field("m_c2_r1", e.m_c2_r1, got.m_c2_r1);
			check_field("m_c2_r2", e.m_c2_r2, got.m_c2_r2);
			check_field("zero_axis", e.zero_axis, got.zero_axis);
		endfunction
	endclass

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_ready;
	item_t   item;
	logic    result_valid;
	logic    result_ready;
	result_t result;

	matrix_scoreboard board;
	bit               sending_done;

	axis_angle_rotation_matrix u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// valid stays high into the next beat when there is no gap
	task automatic send_beat(item_t it);
		int gap;
		gap = $urandom_range(0, 4);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		do
			@(posedge clk);
		while (!item_ready);
		board.note_item(it);
	endtask

	function automatic logic signed [15:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'(signed'($urandom_range(0, 6)) - 3);
			3: return 16'(signed'($urandom_range(0, 400)) - 200);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_pattern(int a, int x, int y, int z);
		item_t it;
		it.angle = 16'(a);
		it.axis_x = 16'(x);
		it.axis_y = 16'(y);
		it.axis_z = 16'(z);
		send_beat(it);
	endtask

	initial begin
		item_t it;
		board = new();
		sending_done = 0;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_pattern(0, 3, 4, 5);
		send_pattern(0, 0, 0, 0);
		send_pattern(1000, 0, 0, 0);
		send_pattern(-32768, 0, 0, 0);
		send_pattern(12868, 0, 0, 1);
		send_pattern(12868, 1, 0, 0);
		send_pattern(-12868, 0, 7, 0);
		send_pattern(25736, 1, 1, 1);
		send_pattern(-25736, -1, 2, -3);
		send_pattern(32767, -32768, -32768, -32768);
		send_pattern(-32768, 32767, 32767, 32767);
		send_pattern(32767, 32767, -32768, 1);
		send_pattern(1, 0, 0, -32768);
		send_pattern(-1, 32767, 0, 0);
		send_pattern(6434, 100, -200, 300);
		send_pattern(-6434, -1, -1, -1);
		send_pattern(19302, 5, 0, -5);
		send_pattern(51472 - 65536, 2, 3, 6);
		item_valid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		for (int n = 0; n < N_RANDOM; n++) begin
			it.angle = pick_value();
			it.axis_x = pick_value();
			it.axis_y = pick_value();
			it.axis_z = pick_value();
			if ($urandom_range(0, 15) == 0) begin
				it.axis_x = 0;
				it.axis_y = 0;
				it.axis_z = 0;
			end
			if ($urandom_range(0, 15) == 0)
				it.angle = 0;
			send_beat(it);
			if (n == N_RANDOM / 2) begin
				item_valid <= 1'b0;
				while (board.pending.size() != 0)
					@(posedge clk);
			end
		end
		item_valid <= 1'b0;
		sending_done = 1;
	end

	initial begin
		result_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			int stall;
			stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 4);
			if (stall > 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ready <= 1'b1;
			do
				@(posedge clk);
			while (!result_valid);
			board.check_result(result);
		end
	end

	initial begin
		wait (sending_done);
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#200000;
		$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire

FILE: files.f
+incdir+sv
sv/aarm_pkg.sv
sv/aarm_front.sv
sv/aarm_cell.sv
sv/aarm_tail.sv
sv/axis_angle_rotation_matrix.sv
bench/testbench.sv
